### rtl/core/hsid_pkg.sv
// ----------------------------------------------------------------------------
// HLL sketch image deserializer package
// Shared result kinds, register indexes, limits and the result word layout.
// ----------------------------------------------------------------------------
package hsid_pkg;

    // Largest precision that a header may carry.
    localparam int unsigned MaxPrecision = 18;

    // Register indexes of the configuration port.
    localparam logic CFG_DENSE_MAGIC  = 1'b0;
    localparam logic CFG_SPARSE_MAGIC = 1'b1;

    typedef enum logic [1:0] {
        KIND_HEADER    = 2'd0,
        KIND_REG_WRITE = 2'd1,
        KIND_EMPTY_END = 2'd2,
        KIND_HDR_ERROR = 2'd3
    } kind_t;

    // One result word as it waits in the output queue.
    typedef struct packed {
        logic        last;
        logic [31:0] seed;
        logic [4:0]  precision;
        logic [5:0]  reg_value;
        logic [17:0] reg_index;
        kind_t       kind;
    } result_t;

endpackage

### rtl/core/hll_sketch_image_deserializer_unit.sv
// ----------------------------------------------------------------------------
// HLL sketch image deserializer
// Parses a serialized HyperLogLog image byte by byte and emits header info,
// register writes, empty-image ends and header errors as result words.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | tdata (low bit up)                          | tuser       | tlast
//  ---------+-----------+---------------------------------------------+-------------+-----------
//  s_*      | in        | data_byte[7:0]                              | first_byte  | -
//  m_*      | out       | reg_index[17:0], reg_value[5:0],            | kind[1:0]   | last
//           |           | precision_out[4:0], seed_out[31:0], 3'b0    |             |
//  cfg_*    | in        | register 0 dense_magic, 1 sparse_magic      | -           | -
//
// Each accepted byte is parsed in the cycle it is accepted: the parser state
// registers and the byte feed a short block of logic whose zero, one or two
// result words go into a four-word output queue at the same clock edge.
// The first result can be taken on the next cycle. A byte is accepted in
// every cycle while the queue has room for two words; a dense body yields
// four words per three bytes, so there the output side (one word a cycle)
// sets the sustained rate. Reset is synchronous and active low; it clears
// the parser, the queue and both magic registers. A stall on m_tready only
// fills the queue, and s_tready drops once fewer than two slots are free.
//
module hll_sketch_image_deserializer_unit
    import hsid_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte[7:0]
    input  logic        s_tuser,   // first_byte

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // reg_index, reg_value, precision_out, seed_out, zeros
    output logic [1:0]  m_tuser,   // kind
    output logic        m_tlast,   // last

    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata
);

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_HEADER = 2'd1,
        PH_BODY   = 2'd2,
        PH_IGNORE = 2'd3
    } phase_t;

    // Configuration registers.
    logic [31:0] dense_magic_reg;
    logic [31:0] sparse_magic_reg;

    // Parser state.
    phase_t      phase_reg,          phase_next;
    logic [3:0]  header_pos_reg,     header_pos_next;
    logic [31:0] word_shift_reg,     word_shift_next;
    logic        sparse_mode_reg,    sparse_mode_next;
    logic [4:0]  precision_reg,      precision_next;
    logic [18:0] entries_left_reg,   entries_left_next;
    logic [17:0] next_index_reg,     next_index_next;
    logic [31:0] bit_accum_reg,      bit_accum_next;
    logic [4:0]  bits_held_reg,      bits_held_next;

    // Output queue.
    result_t     queue_reg [4];
    logic [1:0]  wr_ptr_reg;
    logic [1:0]  rd_ptr_reg;
    logic [2:0]  count_reg;

    logic        s_acc;
    logic        m_acc;
    logic [1:0]  n_res;
    result_t     res0;
    result_t     res1;
    logic [4:0]  item_cur;

    assign s_acc    = s_tvalid && s_tready;
    assign m_acc    = m_tvalid && m_tready;
    assign s_tready = (count_reg <= 3'd2);
    assign m_tvalid = (count_reg != 3'd0);

    assign m_tdata  = {3'b000, queue_reg[rd_ptr_reg].seed, queue_reg[rd_ptr_reg].precision,
                       queue_reg[rd_ptr_reg].reg_value, queue_reg[rd_ptr_reg].reg_index};
    assign m_tuser  = queue_reg[rd_ptr_reg].kind;
    assign m_tlast  = queue_reg[rd_ptr_reg].last;

    // Bits per body entry in the current image.
    assign item_cur = sparse_mode_reg ? (precision_reg + 5'd6) : 5'd6;

    function automatic logic [31:0] low_mask(input logic [4:0] n);
        return (32'h1 << n) - 32'h1;
    endfunction

    always_comb begin
        phase_t      ph;
        logic [3:0]  hp;
        logic [31:0] ws;
        logic [31:0] w;
        logic        sm;
        logic [4:0]  prec;
        logic [18:0] ent;
        logic [17:0] nidx;
        logic [31:0] acc;
        logic [4:0]  held;
        logic [18:0] cap;
        logic [31:0] acc_w;
        logic [4:0]  held_w;
        logic [4:0]  item;
        logic        take1;
        logic        take2;
        logic [4:0]  rest1;
        logic [4:0]  rest2;
        logic [31:0] chunk1;
        logic [31:0] chunk2;
        logic        last1;
        logic        last2;

        phase_next        = phase_reg;
        header_pos_next   = header_pos_reg;
        word_shift_next   = word_shift_reg;
        sparse_mode_next  = sparse_mode_reg;
        precision_next    = precision_reg;
        entries_left_next = entries_left_reg;
        next_index_next   = next_index_reg;
        bit_accum_next    = bit_accum_reg;
        bits_held_next    = bits_held_reg;
        res0  = '0;
        res1  = '0;
        n_res = 2'd0;

        ph = phase_reg;  hp = header_pos_reg;  ws = word_shift_reg;
        sm = sparse_mode_reg;  prec = precision_reg;  ent = entries_left_reg;
        nidx = next_index_reg;  acc = bit_accum_reg;  held = bits_held_reg;
        w = '0;  cap = '0;  acc_w = '0;  held_w = '0;  item = '0;
        take1 = 1'b0;  take2 = 1'b0;  rest1 = '0;  rest2 = '0;
        chunk1 = '0;  chunk2 = '0;  last1 = 1'b0;  last2 = 1'b0;

        if (s_acc) begin
            // A first byte restarts the parser in any phase.
            if (s_tuser) begin
                ph = PH_HEADER;  hp = '0;  ws = '0;  sm = 1'b0;  prec = '0;
                ent = '0;  nidx = '0;  acc = '0;  held = '0;
            end
            phase_next        = ph;
            header_pos_next   = hp;
            word_shift_next   = ws;
            sparse_mode_next  = sm;
            precision_next    = prec;
            entries_left_next = ent;
            next_index_next   = nidx;
            bit_accum_next    = acc;
            bits_held_next    = held;

            case (ph)
                PH_HEADER: begin
                    w = ws | ({24'b0, s_tdata} << {hp[1:0], 3'b000});
                    header_pos_next = hp + 4'd1;
                    if (hp[1:0] != 2'd3) begin
                        word_shift_next = w;
                    end else begin
                        word_shift_next = '0;
                        case (hp[3:2])
                            2'd0: begin
                                // Magic word; sparse wins when both registers match.
                                if (w == sparse_magic_reg) begin
                                    sparse_mode_next = 1'b1;
                                end else if (w == dense_magic_reg) begin
                                    sparse_mode_next = 1'b0;
                                end else begin
                                    phase_next = PH_IGNORE;
                                    res0.kind  = KIND_HDR_ERROR;
                                    res0.last  = 1'b1;
                                    n_res      = 2'd1;
                                end
                            end
                            2'd1: begin
                                if (w < 32'd4 || w > 32'(MaxPrecision)) begin
                                    phase_next = PH_IGNORE;
                                    res0.kind  = KIND_HDR_ERROR;
                                    res0.last  = 1'b1;
                                    n_res      = 2'd1;
                                end else begin
                                    precision_next = w[4:0];
                                end
                            end
                            2'd2: begin
                                res0.kind      = KIND_HEADER;
                                res0.precision = prec;
                                res0.seed      = w;
                                n_res          = 2'd1;
                                if (!sm) begin
                                    phase_next        = PH_BODY;
                                    entries_left_next = 19'd1 << prec;
                                    next_index_next   = '0;
                                    bit_accum_next    = '0;
                                    bits_held_next    = '0;
                                end
                            end
                            default: begin
                                // Entry count of a sparse image, capped at 2^precision.
                                cap = 19'd1 << prec;
                                if (w == 32'd0) begin
                                    phase_next = PH_IGNORE;
                                    res0.kind  = KIND_EMPTY_END;
                                    res0.last  = 1'b1;
                                    n_res      = 2'd1;
                                end else begin
                                    entries_left_next = (w > {13'b0, cap}) ? cap : w[18:0];
                                    phase_next        = PH_BODY;
                                    next_index_next   = '0;
                                    bit_accum_next    = '0;
                                    bits_held_next    = '0;
                                end
                            end
                        endcase
                    end
                end
                PH_BODY: begin
                    acc_w  = {acc[23:0], s_tdata};
                    held_w = held + 5'd8;
                    item   = sm ? (prec + 5'd6) : 5'd6;

                    take1  = (held_w >= item) && (ent != '0);
                    rest1  = held_w - item;
                    chunk1 = (acc_w >> rest1) & low_mask(item);
                    last1  = (ent == 19'd1);

                    take2  = take1 && !last1 && (rest1 >= item);
                    rest2  = rest1 - item;
                    chunk2 = (acc_w >> rest2) & low_mask(item);
                    last2  = (ent == 19'd2);

                    res0.kind      = KIND_REG_WRITE;
                    res0.reg_index = sm ? chunk1[23:6] : nidx;
                    res0.reg_value = chunk1[5:0];
                    res0.last      = last1;
                    res1.kind      = KIND_REG_WRITE;
                    res1.reg_index = sm ? chunk2[23:6] : (nidx + 18'd1);
                    res1.reg_value = chunk2[5:0];
                    res1.last      = last2;

                    if (take2) begin
                        n_res             = 2'd2;
                        bits_held_next    = rest2;
                        bit_accum_next    = acc_w & low_mask(rest2);
                        entries_left_next = ent - 19'd2;
                        next_index_next   = sm ? nidx : (nidx + 18'd2);
                        if (last2) begin
                            phase_next = PH_IGNORE;
                        end
                    end else if (take1) begin
                        n_res             = 2'd1;
                        bits_held_next    = rest1;
                        bit_accum_next    = acc_w & low_mask(rest1);
                        entries_left_next = ent - 19'd1;
                        next_index_next   = sm ? nidx : (nidx + 18'd1);
                        if (last1) begin
                            phase_next = PH_IGNORE;
                        end
                    end else begin
                        bits_held_next = held_w;
                        bit_accum_next = acc_w;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dense_magic_reg  <= '0;
            sparse_magic_reg <= '0;
            phase_reg        <= PH_IDLE;
            header_pos_reg   <= '0;
            word_shift_reg   <= '0;
            sparse_mode_reg  <= 1'b0;
            precision_reg    <= '0;
            entries_left_reg <= '0;
            next_index_reg   <= '0;
            bit_accum_reg    <= '0;
            bits_held_reg    <= '0;
            wr_ptr_reg       <= '0;
            rd_ptr_reg       <= '0;
            count_reg        <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_DENSE_MAGIC:  dense_magic_reg  <= cfg_wdata;
                    CFG_SPARSE_MAGIC: sparse_magic_reg <= cfg_wdata;
                    default: begin
                    end
                endcase
            end

            phase_reg        <= phase_next;
            header_pos_reg   <= header_pos_next;
            word_shift_reg   <= word_shift_next;
            sparse_mode_reg  <= sparse_mode_next;
            precision_reg    <= precision_next;
            entries_left_reg <= entries_left_next;
            next_index_reg   <= next_index_next;
            bit_accum_reg    <= bit_accum_next;
            bits_held_reg    <= bits_held_next;

            if (n_res != 2'd0) begin
                queue_reg[wr_ptr_reg] <= res0;
            end
            if (n_res == 2'd2) begin
                queue_reg[wr_ptr_reg + 2'd1] <= res1;
            end
            wr_ptr_reg <= wr_ptr_reg + n_res;
            if (m_acc) begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            count_reg <= count_reg + {1'b0, n_res} - {2'b00, m_acc};
        end
    end

    // The queue never holds more words than it has slots.
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 3'd4)
        else $error("output queue overflow");

    // A byte dropped while idle or ignoring adds no result.
    a_drop_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && !s_tuser && (phase_reg == PH_IDLE || phase_reg == PH_IGNORE) && !m_acc)
        |=> count_reg == $past(count_reg))
        else $error("result produced outside an image");

    // Between bytes, the body never holds a whole entry's worth of bits.
    a_bits_below_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_BODY) |-> (bits_held_reg < item_cur))
        else $error("bit accumulator kept a complete entry");

    // A final result always moves the parser into the ignore phase.
    a_last_ends_image: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && ((n_res != 2'd0 && res0.last && n_res == 2'd1) ||
                   (n_res == 2'd2 && res1.last)))
        |=> phase_reg == PH_IGNORE)
        else $error("image end without leaving the parse phases");

endmodule
